// ----- design/rod_pkg.sv -----
// shared types, constants and codes of the rans order-0 decoder
package rod_pkg;

  localparam int NUM_SYMBOLS_DEF = 256;
  localparam int SCALE_BITS_DEF  = 12;

  localparam int FUNC_BITS   = 2;
  localparam int SYM_BITS    = 8;
  localparam int FREQ_BITS   = 13;
  localparam int BYTE_BITS   = 8;
  localparam int OWED_BITS   = 3;
  localparam int STATUS_BITS = 2;
  localparam int STATE_BITS  = 32;

  localparam logic [OWED_BITS-1:0]  BOOT_BYTES  = 3'd4;
  localparam logic [STATE_BITS-1:0] LOWER_BOUND = 32'h0080_0000;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_PUSH   = 2'd2,
    FUNC_DECODE = 2'd3
  } func_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_SUM = 2'd1,
    STATUS_SEQ_ERR = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM_RD,
    ST_SUM_ADD,
    ST_SUM_CHK,
    ST_BUILD_RD,
    ST_BUILD_CUM,
    ST_BUILD_FILL,
    ST_DEC_TAB,
    ST_DEC_MUL,
    ST_DEC_UPD,
    ST_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic    accept;
    logic    status_set;
    status_t status_val;
    logic    freq_we;
    logic    end_stream;
    logic    push;
    logic    use_cnt;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    sum_clr;
    logic    sum_add;
    logic    pos_clr;
    logic    cum_we;
    logic    fill;
    logic    mul;
    logic    dec_commit;
    logic    start_ok;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic started;
    logic owed_zero;
    logic cnt_last;
    logic sum_ok;
    logic rem_zero;
  } dp_stat_t;

endpackage

// ----- design/rod_ctrl.sv -----
// controller state machine of the rans order-0 decoder
module rod_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [rod_pkg::FUNC_BITS-1:0]  in_func,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rod_pkg::dp_cmd_t               cmd,
  input  rod_pkg::dp_stat_t              st
);
  import rod_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (func_t'(in_func))
            FUNC_LOAD:   state_nxt = ST_FINISH;
            FUNC_START:  state_nxt = ST_SUM_RD;
            FUNC_PUSH:   state_nxt = ST_FINISH;
            FUNC_DECODE: state_nxt = (st.started && st.owed_zero) ? ST_DEC_TAB : ST_FINISH;
          endcase
        end
      end
      ST_SUM_RD:   state_nxt = ST_SUM_ADD;
      ST_SUM_ADD:  state_nxt = st.cnt_last ? ST_SUM_CHK : ST_SUM_RD;
      ST_SUM_CHK:  state_nxt = st.sum_ok ? ST_BUILD_RD : ST_FINISH;
      ST_BUILD_RD: state_nxt = ST_BUILD_CUM;
      ST_BUILD_CUM: state_nxt = ST_BUILD_FILL;
      ST_BUILD_FILL: begin
        if (st.rem_zero) begin
          state_nxt = st.cnt_last ? ST_FINISH : ST_BUILD_RD;
        end
      end
      ST_DEC_TAB: state_nxt = ST_DEC_MUL;
      ST_DEC_MUL: state_nxt = ST_DEC_UPD;
      ST_DEC_UPD: state_nxt = ST_FINISH;
      ST_FINISH:  state_nxt = out_free ? ST_IDLE : ST_FINISH;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.status_val = STATUS_OK;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept     = 1'b1;
          cmd.status_set = 1'b1;
          unique case (func_t'(in_func))
            FUNC_LOAD: begin
              cmd.freq_we    = 1'b1;
              cmd.end_stream = 1'b1;
            end
            FUNC_START: begin
              cmd.cnt_clr = 1'b1;
              cmd.sum_clr = 1'b1;
            end
            FUNC_PUSH: begin
              if (!st.started || st.owed_zero) begin
                cmd.status_val = STATUS_SEQ_ERR;
              end else begin
                cmd.push = 1'b1;
              end
            end
            FUNC_DECODE: begin
              if (!st.started || !st.owed_zero) begin
                cmd.status_val = STATUS_SEQ_ERR;
              end
            end
          endcase
        end
      end
      ST_SUM_RD: cmd.use_cnt = 1'b1;
      ST_SUM_ADD: begin
        cmd.sum_add = 1'b1;
        cmd.cnt_inc = !st.cnt_last;
      end
      ST_SUM_CHK: begin
        if (st.sum_ok) begin
          cmd.cnt_clr = 1'b1;
          cmd.pos_clr = 1'b1;
        end else begin
          cmd.end_stream = 1'b1;
          cmd.status_set = 1'b1;
          cmd.status_val = STATUS_BAD_SUM;
        end
      end
      ST_BUILD_RD:  cmd.use_cnt = 1'b1;
      ST_BUILD_CUM: cmd.cum_we  = 1'b1;
      ST_BUILD_FILL: begin
        if (!st.rem_zero) begin
          cmd.fill = 1'b1;
        end else if (st.cnt_last) begin
          cmd.start_ok = 1'b1;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_DEC_TAB: ;
      ST_DEC_MUL: cmd.mul        = 1'b1;
      ST_DEC_UPD: cmd.dec_commit = 1'b1;
      ST_FINISH:  cmd.out_load   = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

endmodule

// ----- design/rod_datapath.sv -----
// tables, coder state and decode arithmetic of the rans order-0 decoder
module rod_datapath #(
  parameter int NUM_SYMBOLS = rod_pkg::NUM_SYMBOLS_DEF,
  parameter int SCALE_BITS  = rod_pkg::SCALE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rod_pkg::dp_cmd_t                 cmd,
  output rod_pkg::dp_stat_t                st,
  input  logic [rod_pkg::SYM_BITS-1:0]     in_symbol_index,
  input  logic [rod_pkg::FREQ_BITS-1:0]    in_freq_value,
  input  logic [rod_pkg::BYTE_BITS-1:0]    in_byte_value,
  output logic [rod_pkg::SYM_BITS-1:0]     out_decoded_symbol,
  output logic [rod_pkg::OWED_BITS-1:0]    out_bytes_owed,
  output logic [rod_pkg::STATUS_BITS-1:0]  out_status
);
  import rod_pkg::*;

  localparam int SYM_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int SCALE_SIZE = 1 << SCALE_BITS;
  localparam int POS_W      = SCALE_BITS + 1;
  localparam int SUM_W      = (FREQ_BITS + SYM_W > POS_W) ? FREQ_BITS + SYM_W : POS_W;
  localparam int HI_W       = STATE_BITS - SCALE_BITS;
  localparam int PROD_W     = FREQ_BITS + HI_W;

  // memories
  logic [FREQ_BITS-1:0]  freq_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] freq_vld_r;
  logic [SCALE_BITS-1:0] cum_mem  [NUM_SYMBOLS];
  logic [SYM_BITS-1:0]   slot_mem [SCALE_SIZE];

  logic [FREQ_BITS-1:0]  freq_rd_r;
  logic                  freq_vld_rd_r;
  logic [SCALE_BITS-1:0] cum_rd_r;
  logic [SYM_BITS-1:0]   slot_rd_r;

  logic [SYM_W-1:0]      cnt_r;
  logic [SUM_W-1:0]      sum_r;
  logic [POS_W-1:0]      pos_r;
  logic [FREQ_BITS-1:0]  rem_r;
  logic [PROD_W-1:0]     prod_r;

  logic [STATE_BITS-1:0] coder_state_r;
  logic [OWED_BITS-1:0]  owed_r;
  logic                  started_r;

  logic [SYM_BITS-1:0]   res_sym_r;
  status_t               res_status_r;

  logic                  load_ok;
  logic [SYM_W-1:0]      load_addr;
  logic [SYM_W-1:0]      rd_addr;
  logic [SYM_W-1:0]      dec_sym;
  logic [FREQ_BITS-1:0]  freq_eff;
  logic [STATE_BITS-1:0] state_new;
  logic [OWED_BITS-1:0]  owed_new;

  assign load_ok   = ({1'b0, in_symbol_index} < (SYM_BITS + 1)'(NUM_SYMBOLS));
  assign load_addr = in_symbol_index[SYM_W-1:0];
  assign dec_sym   = slot_rd_r[SYM_W-1:0];
  assign rd_addr   = cmd.use_cnt ? cnt_r : dec_sym;
  assign freq_eff  = freq_vld_rd_r ? freq_rd_r : '0;

  // frequency table, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (cmd.freq_we && load_ok) begin
      freq_mem[load_addr] <= in_freq_value;
    end
    freq_rd_r     <= freq_mem[rd_addr];
    freq_vld_rd_r <= freq_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_vld_r <= '0;
    end else if (cmd.freq_we && load_ok) begin
      freq_vld_r[load_addr] <= 1'b1;
    end
  end

  // cumulative table
  always_ff @(posedge clk) begin
    if (cmd.cum_we) begin
      cum_mem[cnt_r] <= pos_r[SCALE_BITS-1:0];
    end
    cum_rd_r <= cum_mem[dec_sym];
  end

  // slot to symbol table
  always_ff @(posedge clk) begin
    if (cmd.fill) begin
      slot_mem[pos_r[SCALE_BITS-1:0]] <= SYM_BITS'(cnt_r);
    end
    slot_rd_r <= slot_mem[coder_state_r[SCALE_BITS-1:0]];
  end

  // table walk and multiply
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + SYM_W'(1);
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + SUM_W'(freq_eff);
    end
    if (cmd.pos_clr) begin
      pos_r <= '0;
    end else if (cmd.fill) begin
      pos_r <= pos_r + POS_W'(1);
    end
    if (cmd.cum_we) begin
      rem_r <= freq_eff;
    end else if (cmd.fill) begin
      rem_r <= rem_r - FREQ_BITS'(1);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(freq_eff) * PROD_W'(coder_state_r[STATE_BITS-1:SCALE_BITS]);
    end
  end

  assign state_new = STATE_BITS'(prod_r) + STATE_BITS'(coder_state_r[SCALE_BITS-1:0])
                     - STATE_BITS'(cum_rd_r);

  // renormalization bytes owed
  always_comb begin
    priority if (state_new >= LOWER_BOUND) begin
      owed_new = OWED_BITS'(0);
    end else if (state_new >= (LOWER_BOUND >> BYTE_BITS)) begin
      owed_new = OWED_BITS'(1);
    end else if (state_new >= (LOWER_BOUND >> (2 * BYTE_BITS))) begin
      owed_new = OWED_BITS'(2);
    end else begin
      owed_new = OWED_BITS'(3);
    end
  end

  // coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coder_state_r <= '0;
      owed_r        <= '0;
      started_r     <= 1'b0;
    end else if (cmd.end_stream) begin
      owed_r    <= '0;
      started_r <= 1'b0;
    end else if (cmd.start_ok) begin
      coder_state_r <= '0;
      owed_r        <= BOOT_BYTES;
      started_r     <= 1'b1;
    end else if (cmd.push) begin
      coder_state_r <= {coder_state_r[STATE_BITS-BYTE_BITS-1:0], in_byte_value};
      owed_r        <= owed_r - OWED_BITS'(1);
    end else if (cmd.dec_commit) begin
      coder_state_r <= state_new;
      owed_r        <= owed_new;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_sym_r <= '0;
    end else if (cmd.dec_commit) begin
      res_sym_r <= slot_rd_r;
    end
    if (cmd.status_set) begin
      res_status_r <= cmd.status_val;
    end
    if (cmd.out_load) begin
      out_decoded_symbol <= res_sym_r;
      out_bytes_owed     <= owed_r;
      out_status         <= res_status_r;
    end
  end

  assign st.started   = started_r;
  assign st.owed_zero = (owed_r == '0);
  assign st.cnt_last  = (cnt_r == SYM_W'(NUM_SYMBOLS - 1));
  assign st.sum_ok    = (sum_r == SUM_W'(SCALE_SIZE));
  assign st.rem_zero  = (rem_r == '0);

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill |-> !pos_r[SCALE_BITS])
    else $error("slot fill past end of scale");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cum_we |-> (sum_r == SUM_W'(SCALE_SIZE)))
    else $error("table build without a good frequency sum");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dec_commit |-> (started_r && owed_r == '0))
    else $error("decode committed while bytes owed or no stream");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (started_r && owed_r != '0))
    else $error("byte pushed with nothing owed");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start_ok |=> (started_r && owed_r == BOOT_BYTES))
    else $error("stream start did not arm bootstrap bytes");

endmodule

// ----- design/rans_order0_decoder.sv -----
// order-0 rans decoder top level: controller plus datapath
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+------------------
//  in      | in_func in_symbol_index in_freq_value in_byte_value | in_valid/in_stall
//  out     | out_decoded_symbol out_bytes_owed out_status       | out_valid/out_stall
//
// load, push and rejected items go straight to the result; a decode steps through slot
// read, table read, multiply, state update and result, all set by the single registered
// read port per table; a start walks the frequency table twice, once to sum it and once
// to build the tables, and stops after the sum pass when the sum is wrong
// one word at a time: in_stall is high from acceptance until the result word is registered
// a stalled result word holds; the next word is taken while it waits
// rst_n clears the stream state and the frequency valid bits, no clearing pass
module rans_order0_decoder #(
  parameter int NUM_SYMBOLS = rod_pkg::NUM_SYMBOLS_DEF,
  parameter int SCALE_BITS  = rod_pkg::SCALE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rod_pkg::FUNC_BITS-1:0]    in_func,
  input  logic [rod_pkg::SYM_BITS-1:0]     in_symbol_index,
  input  logic [rod_pkg::FREQ_BITS-1:0]    in_freq_value,
  input  logic [rod_pkg::BYTE_BITS-1:0]    in_byte_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [rod_pkg::SYM_BITS-1:0]     out_decoded_symbol,
  output logic [rod_pkg::OWED_BITS-1:0]    out_bytes_owed,
  output logic [rod_pkg::STATUS_BITS-1:0]  out_status
);
  import rod_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  rod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  rod_datapath #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .SCALE_BITS  (SCALE_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .st                 (st),
    .in_symbol_index    (in_symbol_index),
    .in_freq_value      (in_freq_value),
    .in_byte_value      (in_byte_value),
    .out_decoded_symbol (out_decoded_symbol),
    .out_bytes_owed     (out_bytes_owed),
    .out_status         (out_status)
  );

endmodule

// ----- tb/tb_rans_order0_decoder.sv -----
// testbench for the rans order-0 decoder: queued stimulus, predicted results and word checks
module tb_rans_order0_decoder;
  import rod_pkg::*;

  localparam int NSYM         = NUM_SYMBOLS_DEF;
  localparam int SCALE        = 1 << SCALE_BITS_DEF;
  localparam int PLAN         = 0;
  localparam int LIVE         = 1;
  localparam int TARGET_ITEMS = 1600;
  localparam int STALL_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    func_t                func;
    logic [SYM_BITS-1:0]  sym;
    logic [FREQ_BITS-1:0] freq;
    logic [BYTE_BITS-1:0] byt;
  } item_t;

  typedef struct packed {
    logic [SYM_BITS-1:0]  sym;
    logic [OWED_BITS-1:0] owed;
    status_t              status;
  } result_t;

  typedef struct packed {
    item_t      item;
    logic       hold;
    logic [1:0] phase;
  } queued_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [FUNC_BITS-1:0]   in_func = '0;
  logic [SYM_BITS-1:0]    in_symbol_index = '0;
  logic [FREQ_BITS-1:0]   in_freq_value = '0;
  logic [BYTE_BITS-1:0]   in_byte_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SYM_BITS-1:0]    out_decoded_symbol;
  logic [OWED_BITS-1:0]   out_bytes_owed;
  logic [STATUS_BITS-1:0] out_status;

  rans_order0_decoder dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_symbol_index    (in_symbol_index),
    .in_freq_value      (in_freq_value),
    .in_byte_value      (in_byte_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_symbol (out_decoded_symbol),
    .out_bytes_owed     (out_bytes_owed),
    .out_status         (out_status)
  );

  // two decoder copies: one shapes the stimulus, one follows accepted words
  logic [FREQ_BITS-1:0]  freq_tab [0:1][NSYM];
  logic [FREQ_BITS-1:0]  cum_tab  [0:1][NSYM];
  logic [SYM_BITS-1:0]   slot_tab [0:1][SCALE];
  logic [STATE_BITS-1:0] coder_x  [0:1];
  logic [OWED_BITS-1:0]  owed     [0:1];
  logic                  started  [0:1];

  queued_t    queued_items[$];
  result_t    pending_results[$];
  logic [1:0] idle_phase = 2'd0;
  int         n_queued = 0;
  int         last_phase = 0;
  int         n_accepted = 0;
  int         n_results_seen = 0;
  int         n_starts = 0;
  int         n_decodes = 0;
  int         n_results = 0;
  int         n_errors = 0;
  int         idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_model(int k);
    for (int s = 0; s < NSYM; s++) begin
      freq_tab[k][s] = '0;
      cum_tab[k][s]  = '0;
    end
    for (int p = 0; p < SCALE; p++) slot_tab[k][p] = '0;
    coder_x[k] = '0;
    owed[k]    = '0;
    started[k] = 1'b0;
  endfunction

  function automatic logic [OWED_BITS-1:0] renorm_bytes(logic [STATE_BITS-1:0] x);
    logic [63:0]          v;
    logic [OWED_BITS-1:0] n;
    v = 64'(x);
    n = '0;
    while (n < 3 && v < 64'(LOWER_BOUND)) begin
      v = v << 8;
      n++;
    end
    return n;
  endfunction

  function automatic result_t decode_item(int k, item_t it);
    result_t                   r;
    int unsigned               sum;
    int unsigned               pos;
    logic [SCALE_BITS_DEF-1:0] slot;
    logic [SYM_BITS-1:0]       s;
    logic [63:0]               x;
    r.sym    = '0;
    r.status = STATUS_OK;
    case (it.func)
      FUNC_LOAD: begin
        if (int'(it.sym) < NSYM) freq_tab[k][it.sym] = it.freq;
        started[k] = 1'b0;
        owed[k]    = '0;
      end
      FUNC_START: begin
        sum = 0;
        for (int i = 0; i < NSYM; i++) sum += freq_tab[k][i];
        if (sum != SCALE) begin
          r.status   = STATUS_BAD_SUM;
          started[k] = 1'b0;
          owed[k]    = '0;
        end else begin
          pos = 0;
          for (int i = 0; i < NSYM; i++) begin
            cum_tab[k][i] = FREQ_BITS'(pos);
            for (int j = 0; j < freq_tab[k][i] && pos < SCALE; j++) begin
              slot_tab[k][pos] = SYM_BITS'(i);
              pos++;
            end
          end
          coder_x[k] = '0;
          owed[k]    = BOOT_BYTES;
          started[k] = 1'b1;
        end
      end
      FUNC_PUSH: begin
        if (!started[k] || owed[k] == 0) begin
          r.status = STATUS_SEQ_ERR;
        end else begin
          coder_x[k] = {coder_x[k][STATE_BITS-9:0], it.byt};
          owed[k]    = owed[k] - 1'b1;
        end
      end
      FUNC_DECODE: begin
        if (!started[k] || owed[k] != 0) begin
          r.status = STATUS_SEQ_ERR;
        end else begin
          slot = coder_x[k][SCALE_BITS_DEF-1:0];
          s    = slot_tab[k][slot];
          x    = 64'(freq_tab[k][s]) * 64'(coder_x[k] >> SCALE_BITS_DEF)
               + 64'(slot) - 64'(cum_tab[k][s]);
          coder_x[k] = x[STATE_BITS-1:0];
          owed[k]    = renorm_bytes(coder_x[k]);
          r.sym      = s;
        end
      end
    endcase
    r.owed = owed[k];
    return r;
  endfunction

  function automatic int idle_pct(bit receiver, logic [1:0] phase);
    case (phase)
      2'd0:    return receiver ? 69 : 23;
      2'd1:    return receiver ? 23 : 69;
      default: return 0;
    endcase
  endfunction

  function automatic logic [BYTE_BITS-1:0] rand_byte();
    return ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
  endfunction

  task automatic queue_item(func_t f, logic [SYM_BITS-1:0] s, logic [FREQ_BITS-1:0] fq,
                            logic [BYTE_BITS-1:0] b, bit hold = 1'b0);
    queued_t q;
    q.item.func = f;
    q.item.sym  = s;
    q.item.freq = fq;
    q.item.byt  = b;
    q.phase     = (n_queued * 3 < TARGET_ITEMS) ? 2'd0 :
                  (n_queued * 3 < 2 * TARGET_ITEMS) ? 2'd1 : 2'd2;
    q.hold      = hold || (int'(q.phase) != last_phase);
    last_phase  = q.phase;
    void'(decode_item(PLAN, q.item));
    queued_items.push_back(q);
    n_queued++;
  endtask

  task automatic load_table(int n);
    logic [FREQ_BITS-1:0] nf [NSYM];
    int left;
    int f;
    int s;
    for (int i = 0; i < NSYM; i++) nf[i] = (n == NSYM) ? FREQ_BITS'(SCALE / NSYM) : '0;
    if (n != NSYM) begin
      left = SCALE;
      for (int k = 0; k < n; k++) begin
        do s = $urandom_range(0, NSYM - 1); while (nf[s] != 0);
        f = (k == n - 1) ? left : $urandom_range(1, left - (n - 1 - k));
        nf[s] = FREQ_BITS'(f);
        left -= f;
      end
    end
    for (int i = 0; i < NSYM; i++)
      if (freq_tab[PLAN][i] != nf[i])
        queue_item(FUNC_LOAD, SYM_BITS'(i), nf[i], rand_byte());
  endtask

  function automatic int plan_sum();
    int sum;
    sum = 0;
    for (int i = 0; i < NSYM; i++) sum += freq_tab[PLAN][i];
    return sum;
  endfunction

  // move some weight between two symbols, keeping the sum (a new table when none can give)
  task automatic shift_weight();
    int a;
    int b;
    int d;
    int s0;
    a  = -1;
    s0 = $urandom_range(0, NSYM - 1);
    for (int i = 0; i < NSYM && a < 0; i++)
      if (freq_tab[PLAN][(s0 + i) % NSYM] > 1) a = (s0 + i) % NSYM;
    if (a < 0) begin
      load_table($urandom_range(2, 12));
      return;
    end
    do b = $urandom_range(0, NSYM - 1); while (b == a);
    d = $urandom_range(1, freq_tab[PLAN][a] - 1);
    queue_item(FUNC_LOAD, SYM_BITS'(a), FREQ_BITS'(freq_tab[PLAN][a] - d), rand_byte());
    queue_item(FUNC_LOAD, SYM_BITS'(b), FREQ_BITS'(freq_tab[PLAN][b] + d), rand_byte());
  endtask

  task automatic run_stream(int ndec, int noise_pct);
    queue_item(FUNC_START, 8'($urandom), 13'($urandom_range(0, SCALE)), rand_byte(),
               $urandom_range(0, 9) == 0);
    if (!started[PLAN]) return;
    for (int d = 0; d < ndec; d++) begin
      while (owed[PLAN] != 0) begin
        if ($urandom_range(0, 99) < noise_pct)
          queue_item(FUNC_DECODE, 8'($urandom), 13'($urandom_range(0, SCALE)), rand_byte());
        queue_item(FUNC_PUSH, 8'($urandom), 13'($urandom_range(0, SCALE)), rand_byte());
      end
      if ($urandom_range(0, 99) < noise_pct)
        queue_item(FUNC_PUSH, 8'($urandom), 13'($urandom_range(0, SCALE)), rand_byte());
      queue_item(FUNC_DECODE, 8'($urandom), 13'($urandom_range(0, SCALE)), rand_byte());
    end
  endtask

  task automatic queue_noise(int count);
    repeat (count)
      queue_item(func_t'($urandom_range(0, 3)), 8'($urandom),
                 13'($urandom_range(0, SCALE)), rand_byte());
  endtask

  // driver
  always @(posedge clk) begin : drive
    queued_t q;
    item_t   cur;
    bit      launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) n_results_seen++;
      if (in_valid && !in_stall) begin
        cur.func = func_t'(in_func);
        cur.sym  = in_symbol_index;
        cur.freq = in_freq_value;
        cur.byt  = in_byte_value;
        pending_results.push_back(decode_item(LIVE, cur));
        n_accepted++;
        if (cur.func == FUNC_START) n_starts++;
        if (cur.func == FUNC_DECODE) n_decodes++;
      end
      if (!in_valid || !in_stall) begin
        launch = queued_items.size() != 0;
        if (launch) begin
          launch = !(queued_items[0].hold && n_accepted != n_results_seen) &&
                   $urandom_range(0, 99) >= idle_pct(1'b0, queued_items[0].phase);
        end
        if (launch) begin
          q = queued_items.pop_front();
          in_func         <= q.item.func;
          in_symbol_index <= q.item.sym;
          in_freq_value   <= q.item.freq;
          in_byte_value   <= q.item.byt;
          idle_phase      <= q.phase;
        end
        in_valid <= launch;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("unexpected result word: symbol %0d owed %0d status %0d",
                     out_decoded_symbol, out_bytes_owed, out_status);
        end else begin
          want = pending_results.pop_front();
          if (out_decoded_symbol !== want.sym || out_bytes_owed !== want.owed ||
              out_status !== want.status) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("word %0d mismatch: expected symbol %0d owed %0d status %0d, got symbol %0d owed %0d status %0d",
                       n_results, want.sym, want.owed, want.status,
                       out_decoded_symbol, out_bytes_owed, out_status);
          end
        end
      end
      out_stall <= $urandom_range(0, 99) < idle_pct(1'b1, idle_phase);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    bit first;
    clear_model(PLAN);
    clear_model(LIVE);

    // directed part
    queue_item(FUNC_DECODE, 8'h00, 13'd0, 8'h00);     // decode with no stream
    queue_item(FUNC_PUSH,   8'h00, 13'd0, 8'hFF);     // push with no stream
    queue_item(FUNC_START,  8'h00, 13'd0, 8'h00);     // all-zero table
    queue_item(FUNC_LOAD,   8'hFF, 13'd4096, 8'h00);
    queue_item(FUNC_LOAD,   8'h00, 13'd4096, 8'h00);
    queue_item(FUNC_START,  8'hFF, 13'd4096, 8'hFF);  // sum too large
    queue_item(FUNC_LOAD,   8'h00, 13'd0, 8'hFF);
    queue_item(FUNC_START,  8'h00, 13'd0, 8'h00);
    queue_item(FUNC_DECODE, 8'h00, 13'd0, 8'h00);     // bootstrap bytes still owed
    repeat (4) queue_item(FUNC_PUSH, 8'h00, 13'd0, 8'hFF);
    queue_item(FUNC_PUSH,   8'h00, 13'd0, 8'h55);     // no byte owed
    queue_item(FUNC_DECODE, 8'hFF, 13'd4096, 8'hFF);  // maximum state
    queue_item(FUNC_LOAD,   8'h00, 13'd2048, 8'h00);  // load ends the stream
    queue_item(FUNC_LOAD,   8'hFF, 13'd2048, 8'h00);
    queue_item(FUNC_DECODE, 8'h00, 13'd0, 8'h00);
    queue_item(FUNC_START,  8'h00, 13'd0, 8'h00);
    repeat (4) queue_item(FUNC_PUSH, 8'h00, 13'd0, 8'h00);
    queue_item(FUNC_DECODE, 8'h00, 13'd0, 8'h00);     // zero state owes three
    queue_item(FUNC_PUSH,   8'h00, 13'd0, 8'h00);
    queue_item(FUNC_PUSH,   8'h00, 13'd0, 8'h00);
    queue_item(FUNC_PUSH,   8'h00, 13'd0, 8'h01);
    queue_item(FUNC_DECODE, 8'h00, 13'd0, 8'h00);     // state still below bound
    queue_item(FUNC_START,  8'h00, 13'd0, 8'h00);     // restart over a running stream

    // random part
    first = 1'b1;
    while (n_queued < TARGET_ITEMS) begin
      if (first || $urandom_range(0, 99) < 80) begin
        if (first)
          load_table(NSYM);
        else if (plan_sum() == SCALE && $urandom_range(0, 2) == 0)
          shift_weight();
        else if ($urandom_range(0, 24) == 0)
          load_table(1);
        else
          load_table($urandom_range(2, 12));
        run_stream($urandom_range(3, 40), 6);
        first = 1'b0;
      end else begin
        queue_noise($urandom_range(4, 12));
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (queued_items.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d input words (%0d stream starts, %0d decodes) and %0d result words",
             n_accepted, n_starts, n_decodes, n_results);
    $display("under two stall mixes on both channels and a stall-free stretch");
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
